>>> rtl/core/tile_map_scroll_controller_top_assert.svh
// Assertion macros shared by the tile map scroll controller modules.
`ifndef TILE_MAP_SCROLL_CONTROLLER_TOP_ASSERT_SVH
`define TILE_MAP_SCROLL_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tmsc_pkg.sv
package tmsc_pkg;

    localparam int SCREEN_WIDTH  = 32;
    localparam int MAX_VIEW_ROWS = 24;
    localparam int ROW_W         = $clog2(MAX_VIEW_ROWS + 1);

    // Queue depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] CMD_MOVE_X = 2'd0;
    localparam logic [1:0] CMD_MOVE_Y = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_BASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE = 3'd6;

    localparam logic KIND_ADJUST = 1'b0;
    localparam logic KIND_COPY   = 1'b1;

    typedef struct packed {
        logic [15:0] map_base;
        logic [15:0] layout_base;
        logic [7:0]  map_width;
        logic [7:0]  map_height;
        logic [5:0]  view_width;
        logic [4:0]  view_height;
        logic        wrap_enable;
    } cfg_t;

    typedef struct packed {
        logic [6:0] adj;
        logic [7:0] tx;
        logic [7:0] ty;
        logic       copy;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ADJ,
        ST_ROW_A,
        ST_ROW_B
    } back_state_t;

    function automatic logic [10:0] clamp_move(input logic [10:0] cur,
                                               input logic [7:0] d,
                                               input logic [12:0] limit);
        logic signed [12:0] lim;
        logic signed [12:0] c;
        logic signed [12:0] dd;
        logic signed [12:0] s;
        logic [10:0] res;
        lim = limit[12] ? 13'sd0 : $signed(limit);
        c   = $signed({2'b00, cur});
        dd  = $signed({{5{d[7]}}, d});
        s   = c + dd;
        if (dd > 13'sd0) begin
            res = (s < lim) ? s[10:0] : lim[10:0];
        end
        else begin
            res = (c > -dd) ? s[10:0] : 11'd0;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/tmsc_if.sv
interface tmsc_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic signed [7:0] delta;

    modport source (output valid, output cmd, output delta, input ready);
    modport sink (input valid, input cmd, input delta, output ready);
endinterface

interface tmsc_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  adjust_value;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [5:0]  run_length;
    logic        last;

    modport source (output valid, output kind, output adjust_value, output src_addr,
                    output dst_addr, output run_length, output last, input ready);
    modport sink (input valid, input kind, input adjust_value, input src_addr,
                  input dst_addr, input run_length, input last, output ready);
endinterface

interface tmsc_cfg_if import tmsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/tmsc_front.sv
module tmsc_front import tmsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tmsc_item_if.sink   items,
    tmsc_cfg_if.sink    cfg,
    output cfg_t        cfg_q,
    output logic        push,
    output job_t        push_job,
    input  logic        full
);

    cfg_t        cfg_reg, cfg_next;
    logic [10:0] offset_x_reg, offset_x_next;
    logic [10:0] offset_y_reg, offset_y_next;
    logic [7:0]  shown_x_reg, shown_x_next;
    logic [7:0]  shown_y_reg, shown_y_next;
    logic        shown_valid_reg, shown_valid_next;

    logic        acc;
    logic [7:0]  tx;
    logic [7:0]  ty;
    logic        same;
    logic        d_pos;
    logic [12:0] dext;
    logic [12:0] w8;
    logic [12:0] sum_x;
    logic [12:0] wrap_x;
    logic [12:0] lim_x;
    logic [12:0] lim_y;

    assign cfg.ready   = 1'b1;
    assign items.ready = !full;
    assign acc         = items.valid && items.ready;
    assign cfg_q       = cfg_reg;

    assign tx   = offset_x_reg[10:3];
    assign ty   = offset_y_reg[10:3];
    assign same = shown_valid_reg && (tx == shown_x_reg) && (ty == shown_y_reg);

    assign d_pos = !items.delta[7] && (items.delta != 8'sd0);
    assign dext  = {{5{items.delta[7]}}, items.delta};
    assign w8    = {2'b00, cfg_reg.map_width, 3'b000};
    assign sum_x = {2'b00, offset_x_reg} + dext;
    assign lim_x = ({5'b0, cfg_reg.map_width} - {7'b0, cfg_reg.view_width}) << 3;
    assign lim_y = ({5'b0, cfg_reg.map_height} - {8'b0, cfg_reg.view_height}) << 3;

    always_comb
    begin
        if (d_pos)
        begin
            wrap_x = (sum_x >= w8) ? sum_x - w8 : sum_x;
        end
        else
        begin
            wrap_x = sum_x[12] ? sum_x + w8 : sum_x;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_MAP_BASE:    cfg_next.map_base    = cfg.data;
                REG_LAYOUT_BASE: cfg_next.layout_base = cfg.data;
                REG_MAP_WIDTH:   cfg_next.map_width   = cfg.data[7:0];
                REG_MAP_HEIGHT:  cfg_next.map_height  = cfg.data[7:0];
                REG_VIEW_WIDTH:  cfg_next.view_width  = cfg.data[5:0];
                REG_VIEW_HEIGHT: cfg_next.view_height = cfg.data[4:0];
                REG_WRAP_ENABLE: cfg_next.wrap_enable = cfg.data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        offset_x_next    = offset_x_reg;
        offset_y_next    = offset_y_reg;
        shown_x_next     = shown_x_reg;
        shown_y_next     = shown_y_reg;
        shown_valid_next = shown_valid_reg;
        push             = 1'b0;
        push_job.adj     = {offset_y_reg[2:0], 1'b0, offset_x_reg[2:0]};
        push_job.tx      = tx;
        push_job.ty      = ty;
        push_job.copy    = !same;
        if (acc)
        begin
            case (items.cmd)
                CMD_MOVE_X:
                begin
                    if (cfg_reg.wrap_enable)
                    begin
                        offset_x_next = wrap_x[10:0];
                    end
                    else
                    begin
                        offset_x_next = clamp_move(offset_x_reg, items.delta, lim_x);
                    end
                end
                CMD_MOVE_Y:
                begin
                    offset_y_next = clamp_move(offset_y_reg, items.delta, lim_y);
                end
                CMD_UPDATE:
                begin
                    push = 1'b1;
                    if (!same)
                    begin
                        shown_x_next     = tx;
                        shown_y_next     = ty;
                        shown_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_base    <= 16'd0;
            cfg_reg.layout_base <= 16'd0;
            cfg_reg.map_width   <= 8'd32;
            cfg_reg.map_height  <= 8'd24;
            cfg_reg.view_width  <= 6'd32;
            cfg_reg.view_height <= 5'd24;
            cfg_reg.wrap_enable <= 1'b0;
            offset_x_reg        <= 11'd0;
            offset_y_reg        <= 11'd0;
            shown_x_reg         <= 8'd0;
            shown_y_reg         <= 8'd0;
            shown_valid_reg     <= 1'b0;
        end
        else
        begin
            cfg_reg         <= cfg_next;
            offset_x_reg    <= offset_x_next;
            offset_y_reg    <= offset_y_next;
            shown_x_reg     <= shown_x_next;
            shown_y_reg     <= shown_y_next;
            shown_valid_reg <= shown_valid_next;
        end
    end

endmodule

>>> rtl/core/tmsc_queue.sv
`include "tile_map_scroll_controller_top_assert.svh"

module tmsc_queue import tmsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TMSC_ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, !full, "push into full queue")
    `TMSC_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, pop, !empty, "pop from empty queue")

endmodule

>>> rtl/core/tmsc_back.sv
`include "tile_map_scroll_controller_top_assert.svh"

module tmsc_back import tmsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg_q,
    input  logic          empty,
    input  job_t          pop_job,
    output logic          pop,
    tmsc_result_if.source results
);

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [15:0]      src_reg, src_next;
    logic [15:0]      dst_reg, dst_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [6:0]  adj_reg, adj_next;
    logic [15:0] src_out_reg, src_out_next;
    logic [15:0] dst_out_reg, dst_out_next;
    logic [5:0]  len_reg, len_next;
    logic        last_reg, last_next;

    logic             load;
    logic [ROW_W-1:0] rows;
    logic             fin;
    logic             split;
    logic [7:0]       sw;
    logic [5:0]       sw6;
    logic [15:0]      src_base;
    logic [15:0]      prod;

    assign load = !out_valid_reg || results.ready;
    assign rows = (cfg_q.view_height > 5'(MAX_VIEW_ROWS)) ? ROW_W'(MAX_VIEW_ROWS)
                                                          : ROW_W'(cfg_q.view_height);
    assign fin   = ({1'b0, row_reg} + 1'b1) == {1'b0, rows};
    assign split = cfg_q.wrap_enable &&
                   (({1'b0, job_reg.tx} + {3'b0, cfg_q.view_width}) > {1'b0, cfg_q.map_width});
    assign sw    = (job_reg.tx < cfg_q.map_width) ? cfg_q.map_width - job_reg.tx : 8'd0;
    assign sw6   = sw[5:0];
    assign prod  = job_reg.ty * cfg_q.map_width;
    assign src_base = cfg_q.map_base + prod + {8'b0, job_reg.tx};

    assign results.valid        = out_valid_reg;
    assign results.kind         = kind_reg;
    assign results.adjust_value = adj_reg;
    assign results.src_addr     = src_out_reg;
    assign results.dst_addr     = dst_out_reg;
    assign results.run_length   = len_reg;
    assign results.last         = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !results.ready;
        kind_next      = kind_reg;
        adj_next       = adj_reg;
        src_out_next   = src_out_reg;
        dst_out_next   = dst_out_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    job_next   = pop_job;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                src_next   = src_base;
                dst_next   = cfg_q.layout_base;
                row_next   = '0;
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ADJUST;
                    adj_next       = job_reg.adj;
                    src_out_next   = 16'd0;
                    dst_out_next   = 16'd0;
                    len_next       = 6'd0;
                    last_next      = !job_reg.copy || (rows == '0);
                    state_next     = (!job_reg.copy || (rows == '0)) ? ST_IDLE : ST_ROW_A;
                end
            end
            ST_ROW_A:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_COPY;
                    adj_next       = 7'd0;
                    src_out_next   = src_reg;
                    dst_out_next   = dst_reg;
                    if (split)
                    begin
                        len_next   = sw6;
                        last_next  = 1'b0;
                        state_next = ST_ROW_B;
                    end
                    else
                    begin
                        len_next   = cfg_q.view_width;
                        last_next  = fin;
                        src_next   = src_reg + {8'b0, cfg_q.map_width};
                        dst_next   = dst_reg + 16'(SCREEN_WIDTH);
                        row_next   = row_reg + 1'b1;
                        state_next = fin ? ST_IDLE : ST_ROW_A;
                    end
                end
            end
            ST_ROW_B:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_COPY;
                    adj_next       = 7'd0;
                    src_out_next   = src_reg - {8'b0, job_reg.tx};
                    dst_out_next   = dst_reg + {10'b0, sw6};
                    len_next       = cfg_q.view_width - sw6;
                    last_next      = fin;
                    src_next       = src_reg + {8'b0, cfg_q.map_width};
                    dst_next       = dst_reg + 16'(SCREEN_WIDTH);
                    row_next       = row_reg + 1'b1;
                    state_next     = fin ? ST_IDLE : ST_ROW_A;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        row_reg     <= row_next;
        kind_reg    <= kind_next;
        adj_reg     <= adj_next;
        src_out_reg <= src_out_next;
        dst_out_reg <= dst_out_next;
        len_reg     <= len_next;
        last_reg    <= last_next;
    end

    `TMSC_ASSERT_NEXT(a_pop_starts_setup, clk, rst_n, pop, state_reg == ST_SETUP, "pop did not start setup")
    `TMSC_ASSERT_NEXT(a_adjust_word_first, clk, rst_n, (state_reg == ST_ADJ) && load, out_valid_reg && (kind_reg == KIND_ADJUST), "adjust word not presented")

endmodule

>>> rtl/core/tile_map_scroll_controller_top.sv
// Tile map scroll controller. A move command (horizontal or vertical) is taken while the queue
// is not full and updates the registered pixel offsets; an update command is classified on entry
// and queued (two deep) for the back end, which pops it in its idle state and computes the start
// address in its setup state, then emits one result word per cycle while the output register
// drains: the fine-adjust word, followed, when the tile position changed, by one copy run per
// view row, or two per row when the view wraps across the map edge. Configuration writes are
// taken in any cycle.
module tile_map_scroll_controller_top import tmsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tmsc_item_if.sink     items,
    tmsc_result_if.source results,
    tmsc_cfg_if.sink      cfg
);

    cfg_t cfg_q;
    logic push;
    job_t push_job;
    logic full;
    logic pop;
    job_t pop_job;
    logic empty;

    tmsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .cfg      (cfg),
        .cfg_q    (cfg_q),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    tmsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    tmsc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_q   (cfg_q),
        .empty   (empty),
        .pop_job (pop_job),
        .pop     (pop),
        .results (results)
    );

endmodule
